// ----- rtl/dss_pkg.sv -----
// Shared constants and types for the drum step sequencer.
package dss_pkg;

    localparam int TRACKS        = 4;
    localparam int STEPS         = 16;
    localparam int TRACK_W       = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int MASK_TRACKS   = (TRACKS < 4) ? TRACKS : 4;
    localparam int REFRESH_PAIRS = 16;
    localparam int PAIR_W        = $clog2(REFRESH_PAIRS);

    localparam logic [7:0] KEY_BASE       = 8'd100;
    localparam logic [7:0] LEVEL_ON       = 8'd255;
    localparam logic [7:0] SET_THRESHOLD  = 8'd128;
    localparam logic [7:0] PARAM_SELECT   = 8'd5;
    localparam int         SELECT_DIVISOR = 242;

    // Input opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    // Result kinds
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    typedef logic [STEPS-1:0] t_pattern;

endpackage

// ----- rtl/drum_step_sequencer.sv -----
// Top level of the four-track drum step sequencer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_opcode, i_param, i_value
//  out     | output    | o_out_valid / i_out_ready  | o_kind, o_trigger_mask, o_ui_key,
//          |           |                            | o_ui_level, o_last
//
// A request is decoded in the cycle it is accepted, and a tick or a track change puts its first
// result in the output register in the cycle after; one request per cycle is taken while results
// drain and no refresh burst runs. A track change issues 16 refresh results from the refresh counter,
// one per cycle while the output is not stalled, and the input stays blocked until the last is loaded.
// Synchronous reset clears the pattern flip-flops, the step position, the selected track, the refresh
// counter and the output valid flag. A stalled output holds its result and blocks new requests until it is taken.
module drum_step_sequencer
    import dss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_param,
    input  logic [7:0]  i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [3:0]  o_trigger_mask,
    output logic [7:0]  o_ui_key,
    output logic [7:0]  o_ui_level,
    output logic        o_last
);

    t_pattern           r_pattern [TRACKS];
    logic [STEP_W-1:0]  r_step;
    logic [TRACK_W-1:0] r_track;
    logic               r_burst;
    logic [PAIR_W-1:0]  r_pair;

    logic               r_out_valid;
    logic               r_kind;
    logic [3:0]         r_mask;
    logic [7:0]         r_key;
    logic [7:0]         r_level;
    logic               r_last;

    logic               slot_free;
    logic               accept;
    logic               is_tick;
    logic               is_write;
    logic               is_select;
    logic [7:0]         write_ofs;
    logic [STEP_W-1:0]  write_step;
    logic [9:0]         value_x;
    logic [TRACK_W-1:0] n_sel;
    logic               sel_change;
    logic [3:0]         tick_mask;
    logic [STEP_W-1:0]  n_step;
    logic [PAIR_W-1:0]  pair_idx;
    logic               pair_level;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = slot_free && !r_burst;
    assign accept     = i_in_valid && o_in_ready;

    // Decode the request
    assign is_tick    = (i_opcode == OP_TICK);
    assign write_ofs  = i_param - KEY_BASE;
    assign is_write   = (i_opcode == OP_CONTROL) && (i_param >= KEY_BASE)
                        && (write_ofs < 8'(REFRESH_PAIRS)) && (32'(write_ofs) < STEPS);
    assign write_step = write_ofs[STEP_W-1:0];
    assign is_select  = (i_opcode == OP_CONTROL) && (i_param == PARAM_SELECT);

    // Pick the track by threshold compares against multiples of the divisor
    assign value_x = 10'(i_value) * 10'(TRACKS);
    always_comb begin
        n_sel = '0;
        for (int k = 1; k < TRACKS; k++) begin
            if (32'(value_x) >= k * SELECT_DIVISOR) begin
                n_sel = TRACK_W'(k);
            end
        end
    end
    assign sel_change = is_select && (n_sel != r_track);

    // Gather the tracks that fire at the current step
    always_comb begin
        tick_mask = '0;
        for (int t = 0; t < MASK_TRACKS; t++) begin
            tick_mask[t] = r_pattern[t][r_step];
        end
    end
    assign n_step = (32'(r_step) == STEPS - 1) ? '0 : r_step + 1'b1;

    // Refresh pair level: the first pair on a change, then the counter
    assign pair_idx = r_burst ? r_pair : '0;
    always_comb begin
        pair_level = 1'b0;
        if (32'(pair_idx) < STEPS) begin
            pair_level = r_pattern[r_burst ? r_track : n_sel][STEP_W'(pair_idx)];
        end
    end

    // Update pattern, step position and selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                r_pattern[t] <= '0;
            end
            r_step  <= '0;
            r_track <= '0;
        end else if (accept) begin
            if (is_tick) begin
                r_step <= n_step;
            end else if (is_write) begin
                r_pattern[r_track][write_step] <= (i_value > SET_THRESHOLD);
            end else if (sel_change) begin
                r_track <= n_sel;
            end
        end
    end

    // Advance the refresh counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= 1'b0;
            r_pair  <= '0;
        end else if (r_burst) begin
            if (slot_free) begin
                r_pair <= r_pair + 1'b1;
                if (32'(r_pair) == REFRESH_PAIRS - 1) begin
                    r_burst <= 1'b0;
                end
            end
        end else if (accept && sel_change) begin
            r_burst <= 1'b1;
            r_pair  <= PAIR_W'(1);
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_burst || (accept && sel_change)) begin
            if (slot_free) begin
                r_out_valid <= 1'b1;
            end
        end else if (accept && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_burst && slot_free) || (accept && sel_change)) begin
            r_kind  <= KIND_REFRESH;
            r_mask  <= '0;
            r_key   <= KEY_BASE + 8'(pair_idx);
            r_level <= pair_level ? LEVEL_ON : 8'd0;
            r_last  <= (32'(pair_idx) == REFRESH_PAIRS - 1);
        end else if (accept && is_tick) begin
            r_kind  <= KIND_TRIGGER;
            r_mask  <= tick_mask;
            r_key   <= '0;
            r_level <= '0;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_trigger_mask = r_mask;
    assign o_ui_key       = r_key;
    assign o_ui_level     = r_level;
    assign o_last         = r_last;

    // Checks
    a_burst_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst |-> !o_in_ready)
        else $error("request accepted during refresh burst");

    a_trigger_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_TRIGGER) |-> r_last)
        else $error("trigger result not marked last");

    a_burst_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst |-> (r_pair != '0))
        else $error("refresh counter at zero during burst");

    a_change_starts_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && sel_change) |=> (r_burst && r_out_valid && r_kind == KIND_REFRESH))
        else $error("track change did not start refresh burst");

endmodule
